/* hw/rtl/bfd_pkg.sv */
// Shared types, constants and CRC-6 functions for the BiSS-C frame decoder.
`default_nettype none
package bfd_pkg;

  localparam int unsigned NUM_BYTES = 5;
  localparam int unsigned HOLD_BYTES = NUM_BYTES - 1;
  localparam logic [2:0] LAST_BYTE = 3'(HOLD_BYTES);

  localparam logic [1:0] ALIGN_NONE = 2'd0;
  localparam logic [1:0] ALIGN_BIT4 = 2'd1;
  localparam logic [1:0] ALIGN_BIT3 = 2'd2;

  localparam logic [5:0] CRC6_POLY = 6'h03;
  localparam logic [5:0] CRC6_XOROUT = 6'h3f;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } frame_t;

  typedef struct packed {
    logic [19:0] position;
    logic        control_bit;
    logic [5:0]  zero_field;
    logic        error_flag;
    logic        warning_flag;
    logic [5:0]  crc_received;
  } fields_t;

  typedef struct packed {
    fields_t    fields;
    logic [1:0] alignment;
    logic [5:0] crc_computed;
    logic       crc_match;
  } result_t;

  function automatic logic [5:0] crc6_shift6(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      r = {r[4:0], 1'b0} ^ (r[5] ? CRC6_POLY : 6'h00);
    end
    return r;
  endfunction

  function automatic logic [5:0] crc6_groups(input logic [19:0] pos, input logic err,
                                             input logic warn);
    logic [5:0] g [6];
    logic [5:0] acc;
    g[0] = {2'b00, pos[19:16]};
    g[1] = pos[15:10];
    g[2] = pos[9:4];
    g[3] = {pos[3:0], 2'b00};
    g[4] = {4'b0000, err, warn};
    g[5] = 6'h00;
    acc = 6'h00;
    for (int k = 0; k < 6; k++) begin
      acc = g[k] ^ crc6_shift6(acc);
    end
    return acc ^ CRC6_XOROUT;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/bfd_collect.sv */
// Byte collector: counts bytes into a frame and holds the completed frame.
`default_nettype none
module bfd_collect (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          advance,
  output logic               frame_valid,
  output bfd_pkg::frame_t    frame
);
  import bfd_pkg::*;

  logic [2:0]   idx_r, idx_nxt;
  logic [7:0]   bytes_r [HOLD_BYTES];
  logic         fv_r, fv_nxt;
  frame_t       frame_r;
  logic         in_xfer;
  logic         last;

  assign in_ready    = !fv_r || advance;
  assign in_xfer     = in_valid && in_ready;
  assign last        = (idx_r >= LAST_BYTE);
  assign frame_valid = fv_r;
  assign frame       = frame_r;

  always_comb begin
    idx_nxt = idx_r;
    fv_nxt  = fv_r;
    if (fv_r && advance) begin
      fv_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (last) begin
        idx_nxt = 3'd0;
        fv_nxt  = 1'b1;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      fv_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      fv_r  <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (last) begin
        frame_r <= '{b0: bytes_r[0], b1: bytes_r[1], b2: bytes_r[2], b3: bytes_r[3],
                     b4: in_rx_byte};
      end else begin
        bytes_r[idx_r[1:0]] <= in_rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bfd_decode.sv */
// Frame decoder: start-bit search, field unpacking and CRC-6 check.
`default_nettype none
module bfd_decode (
  input  wire bfd_pkg::frame_t  frame,
  input  wire bfd_pkg::fields_t held,
  output bfd_pkg::result_t      result
);
  import bfd_pkg::*;

  fields_t    f;
  logic [1:0] align;
  logic [5:0] crc;

  always_comb begin
    f     = held;
    align = ALIGN_NONE;
    if (frame.b0[4]) begin
      align          = ALIGN_BIT4;
      f.control_bit  = frame.b0[3];
      f.position     = {frame.b0[2:0], frame.b1, frame.b2, frame.b3[7]};
      f.zero_field   = frame.b3[6:1];
      f.error_flag   = frame.b3[0];
      f.warning_flag = frame.b4[7];
      f.crc_received = frame.b4[6:1];
    end else if (frame.b0[3]) begin
      align          = ALIGN_BIT3;
      f.control_bit  = frame.b0[2];
      f.position     = {frame.b0[1:0], frame.b1, frame.b2, frame.b3[7:6]};
      f.zero_field   = frame.b3[5:0];
      f.error_flag   = frame.b4[7];
      f.warning_flag = frame.b4[6];
      f.crc_received = frame.b4[5:0];
    end
    crc = crc6_groups(f.position, f.error_flag, f.warning_flag);
  end

  assign result = '{fields: f, alignment: align, crc_computed: crc,
                    crc_match: (crc == f.crc_received)};

endmodule
`default_nettype wire

/* hw/rtl/bissc_frame_decode_crc6.sv */
// Top level of the BiSS-C frame decoder with CRC-6 check.
//
// Input channel: one received byte per transfer on in_rx_byte, first byte of
// a frame first. Five bytes make one frame; the first four produce nothing.
// Result channel: one result per frame, carrying the unpacked position,
// control, zero field, error and warning bits, the received CRC, the
// computed inverted CRC-6 and a match flag. Alignment 1 or 2 tells where the
// start bit was found; with alignment 0 the previous fields are repeated
// and checked again.
// The fifth byte's transfer loads the frame register; the result register then
// takes the decoded frame from it once the result side can advance.
// Throughput: one byte per cycle while the result side takes each result.
// A stalled result stays on the output register; one more frame waits in
// the frame register, and in_ready falls only when both are full.
// Reset clears the byte count, both valid flags and the held fields.
`default_nettype none
module bissc_frame_decode_crc6 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      out_position,
  output logic [1:0]       out_alignment,
  output logic             out_control_bit,
  output logic [5:0]       out_zero_field,
  output logic             out_error_flag,
  output logic             out_warning_flag,
  output logic [5:0]       out_crc_received,
  output logic [5:0]       out_crc_computed,
  output logic             out_crc_match
);
  import bfd_pkg::*;

  logic    advance;
  logic    frame_valid;
  frame_t  frame;
  fields_t held_r;
  result_t dec;
  result_t res_r;
  logic    out_v_r;

  assign advance = !out_v_r || out_ready;

  bfd_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .advance     (advance),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  bfd_decode u_decode (
    .frame  (frame),
    .held   (held_r),
    .result (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      held_r  <= '0;
    end else if (advance) begin
      out_v_r <= frame_valid;
      if (frame_valid) begin
        held_r <= dec.fields;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_valid) begin
      res_r <= dec;
    end
  end

  assign out_valid        = out_v_r;
  assign out_position     = res_r.fields.position;
  assign out_alignment    = res_r.alignment;
  assign out_control_bit  = res_r.fields.control_bit;
  assign out_zero_field   = res_r.fields.zero_field;
  assign out_error_flag   = res_r.fields.error_flag;
  assign out_warning_flag = res_r.fields.warning_flag;
  assign out_crc_received = res_r.fields.crc_received;
  assign out_crc_computed = res_r.crc_computed;
  assign out_crc_match    = res_r.crc_match;

endmodule
`default_nettype wire

/* hw/rtl/bfd_checker.sv */
// Port-level checker for the BiSS-C frame decoder, bound to the top level.
`default_nettype none
module bfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] out_position,
  input wire logic [1:0]  out_alignment,
  input wire logic [5:0]  out_crc_received,
  input wire logic [5:0]  out_crc_computed,
  input wire logic        out_crc_match
);
  import bfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
                                $stable(out_crc_computed))
    else $error("result changed while stalled");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_crc_match == (out_crc_computed == out_crc_received))
    else $error("crc_match disagrees with the CRC values");

  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alignment == ALIGN_NONE || out_alignment == ALIGN_BIT4 ||
                   out_alignment == ALIGN_BIT3))
    else $error("alignment code out of range");

  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind bissc_frame_decode_crc6 bfd_checker u_bfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_position     (out_position),
  .out_alignment    (out_alignment),
  .out_crc_received (out_crc_received),
  .out_crc_computed (out_crc_computed),
  .out_crc_match    (out_crc_match)
);
`default_nettype wire
